### design/cps_pkg.sv
package cps_pkg;

  // Store depth; the count register is sized so that it can hold the depth itself.
  localparam int unsigned MAX_ENTRIES = 128;
  localparam int unsigned CNT_W       = $clog2(MAX_ENTRIES + 1);
  localparam int unsigned HELD_W      = 8;

  // Command codes
  localparam logic CMD_INSERT = 1'b0;
  localparam logic CMD_TAKE   = 1'b1;

  // Status codes
  localparam logic [1:0] ST_INSERTED = 2'd0;
  localparam logic [1:0] ST_DROPPED  = 2'd1;
  localparam logic [1:0] ST_TAKEN    = 2'd2;
  localparam logic [1:0] ST_EMPTY    = 2'd3;

  typedef struct packed {
    logic        cmd;
    logic        from_ua;
    logic        important;
    logic [15:0] specificity;
    logic [15:0] rule_order;
    logic [15:0] rule_tag;
  } in_word_t;

  typedef struct packed {
    logic [1:0]        status;
    logic              out_from_ua;
    logic              out_important;
    logic [15:0]       out_specificity;
    logic [15:0]       out_rule_order;
    logic [15:0]       out_rule_tag;
    logic [HELD_W-1:0] entries_held;
  } out_word_t;

  typedef struct packed {
    logic        from_ua;
    logic        important;
    logic [15:0] specificity;
    logic [15:0] rule_order;
    logic [15:0] rule_tag;
  } entry_t;

  // Operation broadcast to every cell
  typedef struct packed {
    logic ins;
    logic take;
  } cell_ctl_t;

  typedef logic [33:0] key_t;

  // Two-bit rank keeps the order of the cascade ranks 0, 1, 4, 5:
  // normal built-in, normal other, important other, important built-in.
  function automatic key_t entry_key(input entry_t e);
    logic [1:0] rank;
    rank = {e.important, (e.important ? e.from_ua : ~e.from_ua)};
    return {rank, e.specificity, e.rule_order};
  endfunction

endpackage

### design/cps_cell.sv
module cps_cell
  import cps_pkg::*;
(
  input  logic      clk,
  input  cell_ctl_t ctl,
  input  entry_t    new_entry,
  input  entry_t    left_entry,
  input  logic      left_gt,
  input  entry_t    right_entry,
  input  logic      occupied,
  input  logic      at_tail,
  output entry_t    entry_r,
  output logic      gt
);

  entry_t entry_nxt;

  // Held entry ranks strictly above the incoming one
  assign gt = occupied && (entry_key(entry_r) > entry_key(new_entry));

  always_comb begin
    entry_nxt = entry_r;
    if (ctl.ins) begin
      if (left_gt) begin
        entry_nxt = left_entry;       // make room: shift toward tail
      end else if (gt || at_tail) begin
        entry_nxt = new_entry;        // insertion point
      end
    end else if (ctl.take) begin
      entry_nxt = right_entry;        // shift toward head
    end
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
  end

endmodule

### design/cascade_priority_sorter_unit.sv
// Cascade priority sorter: holds up to MAX_ENTRIES matched-rule entries in
// stable ascending cascade order (rank, then specificity, then rule order,
// then arrival). Every input word gives exactly one result word. A row of
// MAX_ENTRIES cells compares the incoming key against every held key at
// once, and each cell loads from its left neighbour, the new entry or its
// right neighbour, so an insert or a take moves every cell together. A
// result sits in an output register; a new word is taken whenever that
// register is empty or being drained, so one word per cycle is sustained
// while the consumer keeps up. An insert into a full store is dropped with
// status 1; a take from an empty store reports status 3. Payload fields of
// the result are zero unless an entry was taken. entries_held is the count
// after the word, modulo 256.
module cascade_priority_sorter_unit
  import cps_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_word_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_word_t out_data
);

  logic [CNT_W-1:0] count_r, count_nxt;
  logic             out_valid_r, out_valid_nxt;
  out_word_t        out_r, out_nxt;

  logic      accept;
  logic      is_full, is_empty;
  cell_ctl_t ctl;
  entry_t    new_entry;

  entry_t cell_entry [MAX_ENTRIES];
  logic   cell_gt    [MAX_ENTRIES];

  // Output register frees up as it is read, so accept in the same cycle
  assign in_ready = !out_valid_r || out_ready;
  assign accept   = in_valid && in_ready;

  assign is_full  = (count_r == CNT_W'(MAX_ENTRIES));
  assign is_empty = (count_r == '0);

  assign ctl.ins  = accept && (in_data.cmd == CMD_INSERT) && !is_full;
  assign ctl.take = accept && (in_data.cmd == CMD_TAKE) && !is_empty;

  assign new_entry.from_ua     = in_data.from_ua;
  assign new_entry.important   = in_data.important;
  assign new_entry.specificity = in_data.specificity;
  assign new_entry.rule_order  = in_data.rule_order;
  assign new_entry.rule_tag    = in_data.rule_tag;

  // Cell row; cell 0 is the head (lowest priority, first to apply).
  // Occupancy comes from the count, the store itself has no valid bits.
  for (genvar i = 0; i < MAX_ENTRIES; i++) begin : g_cell
    entry_t left_e, right_e;
    logic   left_g;

    if (i == 0) begin : g_head
      assign left_e = new_entry;
      assign left_g = 1'b0;
    end else begin : g_mid
      assign left_e = cell_entry[i-1];
      assign left_g = cell_gt[i-1];
    end

    if (i == MAX_ENTRIES - 1) begin : g_tail
      assign right_e = cell_entry[i];
    end else begin : g_body
      assign right_e = cell_entry[i+1];
    end

    cps_cell u_cell (
      .clk         (clk),
      .ctl         (ctl),
      .new_entry   (new_entry),
      .left_entry  (left_e),
      .left_gt     (left_g),
      .right_entry (right_e),
      .occupied    (CNT_W'(i) < count_r),
      .at_tail     (CNT_W'(i) == count_r),
      .entry_r     (cell_entry[i]),
      .gt          (cell_gt[i])
    );
  end

  always_comb begin
    count_nxt = count_r;
    if (ctl.ins) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (ctl.take) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_nxt       = out_r;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    if (accept) begin
      out_valid_nxt = 1'b1;
      out_nxt       = '0;
      if (in_data.cmd == CMD_INSERT) begin
        out_nxt.status = is_full ? ST_DROPPED : ST_INSERTED;
      end else if (is_empty) begin
        out_nxt.status = ST_EMPTY;
      end else begin
        out_nxt.status          = ST_TAKEN;
        out_nxt.out_from_ua     = cell_entry[0].from_ua;
        out_nxt.out_important   = cell_entry[0].important;
        out_nxt.out_specificity = cell_entry[0].specificity;
        out_nxt.out_rule_order  = cell_entry[0].rule_order;
        out_nxt.out_rule_tag    = cell_entry[0].rule_tag;
      end
      out_nxt.entries_held = HELD_W'(count_nxt);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_r <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

### test/testbench.sv
module testbench
  import cps_pkg::*;
();

  // Watchdog: cycles with no word moving on either channel before giving up.
  // Longest honest quiet spell is a sender gap or a drain pause behind a
  // receiver stall.
  localparam int unsigned QUIET_LIMIT = 5000;

  // A queued stimulus word; drain holds the sender off until every
  // outstanding result has come back.
  typedef struct {
    in_word_t word;
    bit       drain;
  } pending_t;

  logic      clk       = 1'b0;
  logic      rst_n     = 1'b0;
  logic      in_valid  = 1'b0;
  logic      in_ready;
  in_word_t  in_data   = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_word_t out_data;

  pending_t    pending_words[$];
  out_word_t   expected_words[$];
  entry_t      held_rules[$];      // predicted store, head = first to apply
  int unsigned words_in    = 0;
  int unsigned words_out   = 0;
  int unsigned quiet_count = 0;
  int unsigned burst_left  = 1;
  int unsigned gap_left    = 0;
  logic [8:0]  stall_tick  = '0;
  bit          failed      = 1'b0;

  cascade_priority_sorter_unit u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  // Cascade rank 0/1/4/5 above specificity above rule order; arrival order is
  // handled by where the insert lands, not by the key.
  function automatic logic [34:0] cascade_key(input entry_t e);
    logic [2:0] rank;
    if (e.important) begin
      rank = e.from_ua ? 3'd5 : 3'd4;
    end else begin
      rank = e.from_ua ? 3'd0 : 3'd1;
    end
    return {rank, e.specificity, e.rule_order};
  endfunction

  // Applies one accepted word to the predicted store and returns its result.
  function automatic out_word_t apply_word(input in_word_t w);
    out_word_t r;
    entry_t    e;
    int        pos;
    r = '0;
    e = {w.from_ua, w.important, w.specificity, w.rule_order, w.rule_tag};
    if (w.cmd == CMD_INSERT) begin
      if (held_rules.size() >= MAX_ENTRIES) begin
        r.status = ST_DROPPED;
      end else begin
        // walk back past strictly greater keys only, so equals keep arrival order
        pos = held_rules.size();
        while (pos > 0 && cascade_key(held_rules[pos-1]) > cascade_key(e)) pos--;
        held_rules.insert(pos, e);
        r.status = ST_INSERTED;
      end
    end else if (held_rules.size() == 0) begin
      r.status = ST_EMPTY;
    end else begin
      e = held_rules.pop_front();
      r.status          = ST_TAKEN;
      r.out_from_ua     = e.from_ua;
      r.out_important   = e.important;
      r.out_specificity = e.specificity;
      r.out_rule_order  = e.rule_order;
      r.out_rule_tag    = e.rule_tag;
    end
    r.entries_held = HELD_W'(held_rules.size());
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  task automatic queue_word(input logic cmd, input logic ua, input logic imp,
                            input logic [15:0] spec, input logic [15:0] order,
                            input logic [15:0] tag, input bit drain = 1'b0);
    pending_t p;
    p.word  = {cmd, ua, imp, spec, order, tag};
    p.drain = drain;
    pending_words.push_back(p);
  endtask

  // Small values often, so that equal keys and near-ties are common; the
  // extremes and the full range otherwise.
  function automatic logic [15:0] rand_field();
    case ($urandom_range(0, 3))
      0:       return 16'($urandom_range(0, 3));
      1:       return $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic queue_random(input logic cmd, input bit drain = 1'b0);
    queue_word(cmd, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
               rand_field(), rand_field(), 16'($urandom), drain);
  endtask

  // ---------------------------------------------------------------------------
  // Sender: bursts of random length with random gaps; the word accepted at
  // this edge is predicted here, and the next one loaded in the same step.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : sender
    logic     accepted;
    pending_t nxt;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      accepted = in_valid && in_ready;
      if (accepted) begin
        expected_words.push_back(apply_word(in_data));
        words_in <= words_in + 1;
      end
      if (!in_valid || accepted) begin
        if (gap_left != 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (pending_words.size() != 0 &&
                     !(pending_words[0].drain &&
                       (words_in + accepted) != words_out)) begin
          nxt = pending_words.pop_front();
          in_data  <= nxt.word;
          in_valid <= 1'b1;
          burst_left--;
          if (burst_left == 0) begin
            burst_left = $urandom_range(1, 20);
            gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver: checks each result word against the oldest prediction and
  // stalls on its own pattern, which is chosen by stall_tick[8:6].
  // ---------------------------------------------------------------------------
  task automatic check_field(input string name, input int unsigned want,
                             input int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, actual %0d", name, want, got);
      failed = 1'b1;
    end
  endtask

  always @(posedge clk) begin : receiver
    out_word_t want;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        words_out <= words_out + 1;
        if (expected_words.size() == 0) begin
          $error("result word with nothing expected: status %0d", out_data.status);
          failed = 1'b1;
        end else begin
          want = expected_words.pop_front();
          check_field("status",          want.status,          out_data.status);
          check_field("out_from_ua",     want.out_from_ua,     out_data.out_from_ua);
          check_field("out_important",   want.out_important,   out_data.out_important);
          check_field("out_specificity", want.out_specificity, out_data.out_specificity);
          check_field("out_rule_order",  want.out_rule_order,  out_data.out_rule_order);
          check_field("out_rule_tag",    want.out_rule_tag,    out_data.out_rule_tag);
          check_field("entries_held",    want.entries_held,    out_data.entries_held);
        end
      end
      stall_tick <= stall_tick + 1'b1;
      case (stall_tick[8:6])
        3'd2:    out_ready <= 1'($urandom_range(0, 1));
        3'd3:    out_ready <= (stall_tick[1:0] == 2'd0);
        3'd4:    out_ready <= !stall_tick[3];
        3'd5:    out_ready <= ($urandom_range(0, 7) != 0);
        3'd6:    out_ready <= ($urandom_range(0, 3) == 0);
        default: out_ready <= 1'b1;
      endcase
    end
  end

  // Watchdog: quiet cycles on both channels.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_count <= 0;
    end else begin
      quiet_count <= quiet_count + 1;
    end
  end

  initial begin
    while (quiet_count < QUIET_LIMIT) @(posedge clk);
    $display("testbench: FAIL");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Stimulus and end of run
  // ---------------------------------------------------------------------------
  initial begin
    int i;

    // Directed: take from an empty store, all four ranks with the field
    // extremes, equal keys to check arrival order, then drain past empty.
    queue_word(CMD_TAKE,   1'b1, 1'b1, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    queue_word(CMD_INSERT, 1'b1, 1'b0, 16'hFFFF, 16'hFFFF, 16'd1);
    queue_word(CMD_INSERT, 1'b0, 1'b0, 16'h0000, 16'h0000, 16'd2);
    queue_word(CMD_INSERT, 1'b0, 1'b1, 16'h0000, 16'h0000, 16'd3);
    queue_word(CMD_INSERT, 1'b1, 1'b1, 16'h0000, 16'h0000, 16'd4);
    queue_word(CMD_INSERT, 1'b0, 1'b1, 16'hFFFF, 16'hFFFF, 16'd5);
    queue_word(CMD_INSERT, 1'b0, 1'b0, 16'd5,    16'd7,    16'd6);
    queue_word(CMD_INSERT, 1'b0, 1'b0, 16'd5,    16'd7,    16'd7);
    queue_word(CMD_INSERT, 1'b0, 1'b0, 16'd5,    16'd6,    16'd8);
    queue_word(CMD_INSERT, 1'b0, 1'b0, 16'd6,    16'd0,    16'd9);
    queue_word(CMD_INSERT, 1'b1, 1'b0, 16'h0000, 16'h0000, 16'hFFFF);
    for (i = 0; i < 11; i++) queue_random(CMD_TAKE);

    // Mixed traffic, insert-leaning so the store builds up; the first word
    // waits for the directed results to drain.
    for (i = 0; i < 150; i++)
      queue_random(($urandom_range(0, 9) < 6) ? CMD_INSERT : CMD_TAKE, i == 0);

    // Fill well past the depth so that later inserts are dropped, then take
    // more than the depth so that the store runs empty.
    for (i = 0; i < 140; i++) queue_random(CMD_INSERT, i == 0);
    for (i = 0; i < 135; i++) queue_random(CMD_TAKE);

    // Balanced traffic from empty.
    for (i = 0; i < 80; i++)
      queue_random($urandom_range(0, 1) ? CMD_INSERT : CMD_TAKE, i == 0);

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Sampled on the falling edge so the sender's updates have settled.
    @(negedge clk);
    while (pending_words.size() != 0 || in_valid || words_in != words_out)
      @(negedge clk);
    repeat (16) @(posedge clk);

    if (expected_words.size() != 0) begin
      $error("%0d result words never arrived", expected_words.size());
      failed = 1'b1;
    end
    if (!failed) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

endmodule

### filelist.f
design/cps_pkg.sv
design/cps_cell.sv
design/cascade_priority_sorter_unit.sv
test/testbench.sv
